/* rtl/pdgf_pkg.sv */
// Shared types, constants and register codes for the PCM downmix, gain and fade block.
package pdgf_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 3'd0,
        CFG_SAMPLE_BYTES  = 3'd1,
        CFG_GAIN_Q12      = 3'd2,
        CFG_FADE_LENGTH   = 3'd3,
        CFG_CLIP_SAMPLES  = 3'd4
    } cfg_idx_t;

    // Format codes; every other code means mono or 8-bit.
    localparam logic [1:0] CH_STEREO = 2'd2;
    localparam logic [1:0] BYTES_16  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [1:0]  CHANNEL_COUNT_RST = 2'd1;
    localparam logic [1:0]  SAMPLE_BYTES_RST  = 2'd2;
    localparam logic [15:0] GAIN_Q12_RST      = 16'd4096;

    localparam int POSITION_WIDTH_DEF = 24;

    // Datapath widths. The gained magnitude is below 2^31 and a fade factor
    // is below the effective fade length, which fits in 24 bits.
    localparam int LEN_W    = 24;
    localparam int MAG_W    = 17;
    localparam int GAIN_W   = 16;
    localparam int M_W      = 31;
    localparam int FACT_W   = 24;
    localparam int HALF_W   = FACT_W / 2;
    localparam int PROD_W   = M_W + FACT_W;
    localparam int DIV_STEPS = M_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam int         Q_SHIFT     = 12;
    localparam logic [31:0] ROUND_BIAS = 32'd4095;
    localparam logic [19:0] SAT_NEG_MAG = 20'd32768;
    localparam logic [18:0] SAT_POS_MAX = 19'd32767;
    localparam logic [15:0] SAMPLE_MIN  = 16'h8000;
    localparam logic [15:0] SAMPLE_MAX  = 16'h7FFF;

    typedef struct packed {
        logic [1:0]        channel_count;
        logic [1:0]        sample_bytes;
        logic [GAIN_W-1:0] gain_q12;
        logic [LEN_W-1:0]  fade_length;
        logic [LEN_W-1:0]  clip_samples;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic capture;
        logic gain;
        logic mul_lo;
        logic mul_hi;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic fade_on;
    } dp_stat_t;

endpackage

/* rtl/pdgf_if.sv */
// Channel interfaces: PCM frame input, mono sample output and configuration writes.
interface pdgf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte0;
    logic [7:0] frame_byte1;
    logic [7:0] frame_byte2;
    logic [7:0] frame_byte3;
    logic       first_of_clip;

    modport source (output valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                    first_of_clip, input ready);
    modport sink   (input valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                    first_of_clip, output ready);
endinterface

interface pdgf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] mono_sample;
    logic               clipped;

    modport source (output valid, mono_sample, clipped, input ready);
    modport sink   (input valid, mono_sample, clipped, output ready);
endinterface

interface pdgf_cfg_if
    import pdgf_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/pdgf_cfg.sv */
// Configuration register file written through the configuration channel.
module pdgf_cfg
    import pdgf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pdgf_cfg_if.sink   cfg,
    output cfg_regs_t  regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CHANNEL_COUNT: regs_next.channel_count = cfg.data[1:0];
                CFG_SAMPLE_BYTES:  regs_next.sample_bytes  = cfg.data[1:0];
                CFG_GAIN_Q12:      regs_next.gain_q12      = cfg.data[GAIN_W-1:0];
                CFG_FADE_LENGTH:   regs_next.fade_length   = cfg.data[LEN_W-1:0];
                CFG_CLIP_SAMPLES:  regs_next.clip_samples  = cfg.data[LEN_W-1:0];
                default:           regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.channel_count <= CHANNEL_COUNT_RST;
            regs_reg.sample_bytes  <= SAMPLE_BYTES_RST;
            regs_reg.gain_q12      <= GAIN_Q12_RST;
            regs_reg.fade_length   <= '0;
            regs_reg.clip_samples  <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

/* rtl/pdgf_ctrl.sv */
// Controller state machine that sequences decode, gain, fade multiply and divide.
module pdgf_ctrl
    import pdgf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;
    logic             div_last;

    assign out_free = !out_valid_reg || out_ready;
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                state_next = stat.fade_on ? ST_MUL_LO : ST_ROUND;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_GAIN:   cmd.gain   = 1'b1;
            ST_MUL_LO: cmd.mul_lo = 1'b1;
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                cnt_next   = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
            end
            ST_ROUND:
            begin
                cmd.load_out = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/pdgf_datapath.sv */
// Datapath: frame decode, gain multiply, fade multiply, serial divide and saturation.
module pdgf_datapath
    import pdgf_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         frame_byte0,
    input  logic [7:0]         frame_byte1,
    input  logic [7:0]         frame_byte2,
    input  logic [7:0]         frame_byte3,
    input  logic               first_of_clip,
    input  cfg_regs_t          regs,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic signed [15:0] mono_sample,
    output logic               clipped
);

    localparam int PW = POSITION_WIDTH;
    localparam int TW = ((PW > LEN_W) ? PW : LEN_W) + 2;

    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_cur_reg;
    logic [PW-1:0]     pos_start;
    logic [7:0]        b0_reg, b1_reg, b2_reg, b3_reg;
    logic [M_W-1:0]    m_reg;
    logic [M_W-1:0]    m_next;
    logic              neg_reg;
    logic [FACT_W-1:0] factor_reg;
    logic [FACT_W-1:0] factor_next;
    logic              fade_used_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic [15:0]       sample_reg;
    logic [15:0]       sample_next;
    logic              clipped_reg;
    logic              clipped_next;

    // Decode.
    logic signed [16:0] sum16;
    logic [8:0]         sum8;
    logic signed [15:0] x;
    logic [MAG_W-1:0]   mag;
    logic [MAG_W+GAIN_W-1:0] gain_prod;

    // Fade window.
    logic [LEN_W-1:0] f_eff;
    logic [TW-1:0]    pos_ext;
    logic [TW-1:0]    f_ext;
    logic [TW-1:0]    tail;
    logic             tail_neg;
    logic             pos_lt_f;
    logic             tail_lt_f;

    // Divide and final scaling.
    logic [FACT_W:0]   rem2;
    logic              q_bit;
    logic [FACT_W-1:0] rem_new;
    logic [M_W-1:0]    m_fin;
    logic [31:0]       bias_sum;
    logic [19:0]       q_neg;
    logic [18:0]       q_pos;

    assign pos_start = first_of_clip ? '0 : pos_reg;

    always_comb
    begin
        sum16 = 17'(signed'({b1_reg, b0_reg})) + 17'(signed'({b3_reg, b2_reg}));
        sum8  = 9'(b0_reg) + 9'(b1_reg);
        if (regs.channel_count == CH_STEREO)
        begin
            if (regs.sample_bytes == BYTES_16)
                x = sum16[16:1];
            else
                x = {sum8 ^ 9'h100, 7'b0};
        end
        else
        begin
            if (regs.sample_bytes == BYTES_16)
                x = {b1_reg, b0_reg};
            else
                x = {b0_reg ^ 8'h80, 8'b0};
        end
        mag       = x[15] ? (MAG_W'(0) - MAG_W'(x)) : MAG_W'(x);
        gain_prod = mag * regs.gain_q12;
        m_next    = gain_prod[M_W-1:0];
    end

    always_comb
    begin
        f_eff     = (regs.fade_length > (regs.clip_samples >> 1)) ?
                    (regs.clip_samples >> 1) : regs.fade_length;
        pos_ext   = TW'(pos_cur_reg);
        f_ext     = TW'(f_eff);
        tail      = TW'(regs.clip_samples) - TW'(1) - pos_ext;
        tail_neg  = tail[TW-1];
        pos_lt_f  = pos_ext < f_ext;
        tail_lt_f = tail_neg || (tail < f_ext);
        stat.fade_on = (f_eff != '0) && (pos_lt_f || tail_lt_f);
        if (pos_lt_f)
            factor_next = pos_ext[FACT_W-1:0];
        else if (tail_neg)
            factor_next = '0;
        else
            factor_next = tail[FACT_W-1:0];
    end

    // Restoring divide: the upper bits of prod_reg hold the partial remainder,
    // the lower bits shift dividend bits out and quotient bits in.
    always_comb
    begin
        rem2    = prod_reg[PROD_W-1 -: FACT_W+1];
        q_bit   = rem2 >= {1'b0, f_eff};
        rem_new = q_bit ? FACT_W'(rem2 - {1'b0, f_eff}) : rem2[FACT_W-1:0];
        prod_next = prod_reg;
        if (cmd.mul_lo)
            prod_next = PROD_W'(m_reg) * PROD_W'(factor_reg[HALF_W-1:0]);
        else if (cmd.mul_hi)
            prod_next = prod_reg +
                        ((PROD_W'(m_reg) * PROD_W'(factor_reg[FACT_W-1:HALF_W])) << HALF_W);
        else if (cmd.div_step)
            prod_next = {rem_new, prod_reg[M_W-2:0], q_bit};
    end

    always_comb
    begin
        m_fin    = fade_used_reg ? prod_reg[M_W-1:0] : m_reg;
        bias_sum = 32'(m_fin) + ROUND_BIAS;
        q_neg    = bias_sum[31:Q_SHIFT];
        q_pos    = m_fin[M_W-1:Q_SHIFT];
        if (neg_reg)
        begin
            clipped_next = q_neg > SAT_NEG_MAG;
            sample_next  = clipped_next ? SAMPLE_MIN : (16'h0 - q_neg[15:0]);
        end
        else
        begin
            clipped_next = q_pos > SAT_POS_MAX;
            sample_next  = clipped_next ? SAMPLE_MAX : q_pos[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (cmd.capture)
            pos_reg <= pos_start + PW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_cur_reg <= pos_start;
            b0_reg      <= frame_byte0;
            b1_reg      <= frame_byte1;
            b2_reg      <= frame_byte2;
            b3_reg      <= frame_byte3;
        end
        if (cmd.gain)
        begin
            m_reg         <= m_next;
            neg_reg       <= x[15];
            factor_reg    <= factor_next;
            fade_used_reg <= stat.fade_on;
        end
        prod_reg <= prod_next;
        if (cmd.load_out)
        begin
            sample_reg  <= sample_next;
            clipped_reg <= clipped_next;
        end
    end

    assign mono_sample = signed'(sample_reg);
    assign clipped     = clipped_reg;

endmodule

/* rtl/pcm_downmix_gain_fade.sv */
// Top level of the PCM stereo-to-mono downmix with gain and linear edge fades.
//
//   channel | dir | handshake       | payload
//   --------+-----+-----------------+--------------------------------------------
//   pcm     | in  | valid / ready   | frame_byte0..3, first_of_clip
//   mono    | out | valid / ready   | mono_sample (signed Q15), clipped
//   cfg     | in  | valid / ready   | index, data (register write)
//
// A frame without an active fade goes from capture through the gain state to the round
// state; a frame inside a fade window also passes the split fade multiply (low and high
// halves) and the 31-step restoring divider, which handle one frame at a time. The next
// frame is taken in the cycle after the result is loaded.
// The result sits in an output register, so a new frame is taken while it waits.
// Reset is asynchronous and active low; it restores register defaults and position 0.
// A stalled output holds its sample; a new result then waits in the controller's final state.
module pcm_downmix_gain_fade
    import pdgf_pkg::*;
#(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    pdgf_in_if.sink   pcm,
    pdgf_out_if.source mono,
    pdgf_cfg_if.sink  cfg
);

    cfg_regs_t regs;
    dp_cmd_t   cmd;
    dp_stat_t  stat;

    pdgf_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pdgf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pcm.valid),
        .in_ready  (pcm.ready),
        .out_valid (mono.valid),
        .out_ready (mono.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pdgf_datapath #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_byte0   (pcm.frame_byte0),
        .frame_byte1   (pcm.frame_byte1),
        .frame_byte2   (pcm.frame_byte2),
        .frame_byte3   (pcm.frame_byte3),
        .first_of_clip (pcm.first_of_clip),
        .regs          (regs),
        .cmd           (cmd),
        .stat          (stat),
        .mono_sample   (mono.mono_sample),
        .clipped       (mono.clipped)
    );

endmodule

/* rtl/pdgf_checker.sv */
// Port-level checker for the downmix block and its bind to the top level.
module pdgf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_sample,
    input logic        out_clipped
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
            pending_next = pending_reg + 2'd1;
        else if (out_xfer && !in_xfer)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // A stalled result keeps its sample and flag.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_clipped))
        else $error("result changed while stalled");

    // One frame is worked on at a time, so no transfer follows directly on another.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !in_ready)
        else $error("input taken in the cycle after a transfer");

    // A result never appears in the cycle right after its frame arrives.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !$rose(out_valid))
        else $error("result appeared too early");

    // Results only exist for frames taken, and at most two frames are in the block.
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != 2'd3) && !(out_valid && pending_reg == 2'd0))
        else $error("result count does not match frames taken");

endmodule

bind pcm_downmix_gain_fade pdgf_checker u_pdgf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pcm.valid),
    .in_ready    (pcm.ready),
    .out_valid   (mono.valid),
    .out_ready   (mono.ready),
    .out_sample  (mono.mono_sample),
    .out_clipped (mono.clipped)
);

/* test/pcm_downmix_gain_fade_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the PCM downmix, gain and fade block with a scoreboard class.
module pcm_downmix_gain_fade_test;
    import pdgf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_FRAMES = 950;
    localparam int IDLE_PERCENT  = 14;
    localparam int SETTLE_CYCLES = 60;
    localparam int REPORT_LIMIT  = 10;

    // Format codes besides the ones the package names.
    localparam logic [1:0] CH_MONO      = 2'd1;
    localparam logic [1:0] BYTES_8      = 2'd1;
    localparam logic [1:0] FORMAT_ZERO  = 2'd0;
    localparam logic [1:0] FORMAT_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic       first_of_clip;
    } pcm_frame_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               clipped;
    } mono_result_t;

    class mono_scoreboard;
        logic [1:0]        channel_count;
        logic [1:0]        sample_bytes;
        logic [GAIN_W-1:0] gain_q12;
        logic [LEN_W-1:0]  fade_length;
        logic [LEN_W-1:0]  clip_samples;
        logic [LEN_W-1:0]  position;
        mono_result_t      predicted[$];
        int                errors;

        function new();
            channel_count = CHANNEL_COUNT_RST;
            sample_bytes  = SAMPLE_BYTES_RST;
            gain_q12      = GAIN_Q12_RST;
            fade_length   = '0;
            clip_samples  = '0;
            position      = '0;
            errors        = 0;
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_CHANNEL_COUNT: channel_count = value[1:0];
                CFG_SAMPLE_BYTES:  sample_bytes  = value[1:0];
                CFG_GAIN_Q12:      gain_q12      = value[GAIN_W-1:0];
                CFG_FADE_LENGTH:   fade_length   = value[LEN_W-1:0];
                CFG_CLIP_SAMPLES:  clip_samples  = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Works out the mono sample for one accepted frame and queues it.
        function void note_frame(pcm_frame_t fr);
            int                left;
            int                right;
            int                level;
            bit                neg;
            longint unsigned   mag;
            longint unsigned   span;
            longint unsigned   rest;
            longint unsigned   q;
            longint            tail;
            logic [LEN_W-1:0]  pos;
            mono_result_t      res;
            if (fr.first_of_clip)
                position = '0;
            pos = position;
            if (channel_count == CH_STEREO)
            begin
                if (sample_bytes == BYTES_16)
                begin
                    left  = $signed({fr.byte1, fr.byte0});
                    right = $signed({fr.byte3, fr.byte2});
                    level = (left + right) >>> 1;
                end
                else
                    level = (int'(fr.byte0) + int'(fr.byte1) - 256) * 128;
            end
            else
            begin
                if (sample_bytes == BYTES_16)
                    level = $signed({fr.byte1, fr.byte0});
                else
                    level = (int'(fr.byte0) - 128) * 256;
            end
            neg = level < 0;
            mag = neg ? -level : level;
            mag = mag * gain_q12;
            span = fade_length;
            if (span > clip_samples / 2)
                span = clip_samples / 2;
            if (span != 0)
            begin
                if (pos < span)
                    mag = mag * pos / span;
                tail = longint'(clip_samples) - 1 - longint'(pos);
                if (tail < longint'(span))
                begin
                    // Frames past the end of the clip fade to silence.
                    rest = (tail < 0) ? 0 : tail;
                    mag = mag * rest / span;
                end
            end
            res.clipped = 1'b0;
            if (neg)
            begin
                q = (mag + 4095) >> 12;
                if (q > 32768)
                begin
                    q = 32768;
                    res.clipped = 1'b1;
                end
                res.sample = 16'(-q);
            end
            else
            begin
                q = mag >> 12;
                if (q > 32767)
                begin
                    q = 32767;
                    res.clipped = 1'b1;
                end
                res.sample = 16'(q);
            end
            predicted.insert(predicted.size(), res);
            position = pos + 1'b1;
        endfunction

        function void check_sample(logic signed [15:0] sample, logic clipped);
            mono_result_t want;
            if (predicted.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected mono sample %0d clipped %0b", sample, clipped);
                return;
            end
            want = predicted.pop_front();
            if (sample !== want.sample || clipped !== want.clipped)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("mismatch: sample %0d expected %0d, clipped %0b expected %0b",
                             sample, want.sample, clipped, want.clipped);
            end
        endfunction

        function int pending();
            return predicted.size();
        endfunction

        function void close();
            if (predicted.size() != 0)
            begin
                errors += predicted.size();
                $display("%0d mono samples never arrived", predicted.size());
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    bit             steady;
    int             cycle_count;
    int             frames_sent;
    mono_scoreboard sb;

    pdgf_in_if  pcm_ch();
    pdgf_out_if mono_ch();
    pdgf_cfg_if cfg_ch();

    pcm_downmix_gain_fade dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pcm   (pcm_ch),
        .mono  (mono_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
        mono_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);

    always @(posedge clk)
        if (rst_n && mono_ch.valid && mono_ch.ready)
            sb.check_sample(mono_ch.mono_sample, mono_ch.clipped);

    function automatic logic [7:0] random_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pcm_frame_t random_frame(logic first);
        pcm_frame_t fr;
        fr.byte0 = random_byte();
        fr.byte1 = random_byte();
        fr.byte2 = random_byte();
        fr.byte3 = random_byte();
        fr.first_of_clip = first;
        return fr;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_frame(input pcm_frame_t fr);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            pcm_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pcm_ch.valid         <= 1'b1;
        pcm_ch.frame_byte0   <= fr.byte0;
        pcm_ch.frame_byte1   <= fr.byte1;
        pcm_ch.frame_byte2   <= fr.byte2;
        pcm_ch.frame_byte3   <= fr.byte3;
        pcm_ch.first_of_clip <= fr.first_of_clip;
        @(posedge clk);
        while (!pcm_ch.ready)
            @(posedge clk);
        sb.note_frame(fr);
        frames_sent++;
        @(negedge clk);
    endtask

    task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3,
                              input logic first);
        send_frame('{b0, b1, b2, b3, first});
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.set_register(idx, value);
        @(negedge clk);
    endtask

    task automatic configure(input logic [1:0] channels, input logic [1:0] bytes,
                             input logic [GAIN_W-1:0] gain, input logic [LEN_W-1:0] fade,
                             input logic [LEN_W-1:0] clip_len);
        write_register(CFG_CHANNEL_COUNT, CFG_DATA_W'(channels));
        write_register(CFG_SAMPLE_BYTES, CFG_DATA_W'(bytes));
        write_register(CFG_GAIN_Q12, CFG_DATA_W'(gain));
        write_register(CFG_FADE_LENGTH, CFG_DATA_W'(fade));
        write_register(CFG_CLIP_SAMPLES, CFG_DATA_W'(clip_len));
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops sending and waits until every queued sample has come back.
    task automatic finish_phase();
        pcm_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int               phase;
        int               count;
        int               run_left;
        int               target;
        bit               short_clip;
        logic             first;
        logic [1:0]       channels;
        logic [1:0]       bytes;
        logic [GAIN_W-1:0] gain;
        logic [LEN_W-1:0] fade;
        logic [LEN_W-1:0] clip_len;

        sb = new();
        pcm_ch.valid         = 1'b0;
        pcm_ch.frame_byte0   = '0;
        pcm_ch.frame_byte1   = '0;
        pcm_ch.frame_byte2   = '0;
        pcm_ch.frame_byte3   = '0;
        pcm_ch.first_of_clip = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_CHANNEL_COUNT;
        cfg_ch.data          = '0;
        mono_ch.ready        = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: mono 16-bit at unity gain, full-scale extremes.
        send_bytes(8'h00, 8'h00, random_byte(), random_byte(), 1'b0);
        send_bytes(8'hFF, 8'h7F, random_byte(), random_byte(), 1'b0);
        send_bytes(8'h00, 8'h80, random_byte(), random_byte(), 1'b0);
        send_bytes(8'hFF, 8'hFF, random_byte(), random_byte(), 1'b0);
        finish_phase();

        // Stereo 16-bit at maximum gain saturates both ways; odd sums round down.
        configure(CH_STEREO, BYTES_16, 16'hFFFF, '0, '0);
        send_bytes(8'hFF, 8'h7F, 8'hFF, 8'h7F, 1'b0);
        send_bytes(8'h00, 8'h80, 8'h00, 8'h80, 1'b0);
        send_bytes(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
        send_bytes(8'h01, 8'h00, 8'hFE, 8'hFF, 1'b0);
        finish_phase();

        // Format codes 0 and 3 act as mono 8-bit.
        configure(FORMAT_ZERO, FORMAT_ZERO, GAIN_Q12_RST, '0, '0);
        send_bytes(8'h00, random_byte(), random_byte(), random_byte(), 1'b0);
        send_bytes(8'hFF, random_byte(), random_byte(), random_byte(), 1'b0);
        finish_phase();
        configure(FORMAT_THREE, FORMAT_THREE, '0, '0, '0);
        send_bytes(8'hFF, random_byte(), random_byte(), random_byte(), 1'b0);
        finish_phase();

        configure(CH_STEREO, BYTES_8, GAIN_Q12_RST, '0, '0);
        send_bytes(8'h00, 8'h00, random_byte(), random_byte(), 1'b0);
        send_bytes(8'hFF, 8'hFF, random_byte(), random_byte(), 1'b0);
        finish_phase();

        // Short clip with fade-in, fade-out and two frames past the end.
        configure(CH_MONO, BYTES_16, GAIN_Q12_RST, 24'd3, 24'd8);
        for (int i = 0; i < 10; i++)
        begin
            if (i % 2 == 0)
                send_bytes(8'hFF, 8'h7F, random_byte(), random_byte(), i == 0);
            else
                send_bytes(8'h00, 8'h80, random_byte(), random_byte(), 1'b0);
        end
        finish_phase();

        target = frames_sent + RANDOM_FRAMES;
        phase = 0;
        while (frames_sent < target)
        begin
            channels = 2'($urandom_range(3));
            bytes    = 2'($urandom_range(3));
            case ($urandom_range(4))
                0: gain = '0;
                1: gain = 16'hFFFF;
                2: gain = GAIN_Q12_RST;
                default: gain = 16'($urandom());
            endcase
            short_clip = 1'b0;
            case ($urandom_range(8))
                0:
                begin
                    fade = '0;
                    clip_len = 24'($urandom());
                end
                1:
                begin
                    fade = 24'hFFFFFF;
                    clip_len = 24'hFFFFFF;
                end
                2:
                begin
                    fade = 24'($urandom());
                    clip_len = 24'($urandom());
                end
                3:
                begin
                    // Fade far longer than half the clip.
                    fade = 24'hFFFFFF;
                    clip_len = 24'($urandom_range(200));
                    short_clip = 1'b1;
                end
                4:
                begin
                    fade = 24'($urandom_range(3));
                    clip_len = 24'($urandom_range(3));
                    short_clip = 1'b1;
                end
                default:
                begin
                    clip_len = 24'($urandom_range(40, 2));
                    fade = 24'($urandom_range(clip_len, 1));
                    short_clip = 1'b1;
                end
            endcase
            configure(channels, bytes, gain, fade, clip_len);

            steady = (phase == 3 || phase == 4);
            count = $urandom_range(90, 40);
            run_left = 0;
            for (int i = 0; i < count; i++)
            begin
                if (i == 0)
                    first = $urandom_range(9) < 8;
                else if (short_clip && run_left == 0)
                    first = 1'b1;
                else
                    first = $urandom_range(99) < 3;
                // A short clip runs up to three frames past its end before the next one starts.
                if (first)
                    run_left = int'(clip_len) + $urandom_range(3);
                if (run_left > 0)
                    run_left--;
                send_frame(random_frame(first));
            end
            finish_phase();
            phase++;
        end
        steady = 1'b0;

        finish_phase();
        repeat (SETTLE_CYCLES) @(negedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
